// ===== rtl/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants for the palette dither pixel engine.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int GRID_STEP_DEF    = 4;
    localparam int FRAME_WIDTH_DEF  = 144;
    localparam int FRAME_HEIGHT_DEF = 168;
    localparam int PALETTE_SIZE_DEF = 256;

    localparam int NUM_STAGES = 9;

    localparam logic [1:0] KIND_FIELD  = 2'd0;
    localparam logic [1:0] KIND_PAL    = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic [7:0] ROUND_MASK = 8'h3f;
    localparam int         ROUND_SH   = 6;
    localparam int         DITH_SH    = 7;
    localparam logic [3:0] ALPHA_CODE = 4'hc;
    localparam logic [1:0] CHAN_MAX   = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_FIELD_WR,
        OP_PAL_WR,
        OP_RENDER
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [5:0]  dith;
        logic [7:0]  pidx;
        logic [23:0] rgb;
    } t_side;

    // 8x8 ordered dither matrix, row-major, index {y[2:0], x[2:0]}
    localparam logic [5:0] BAYER [0:63] = '{
        6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
        6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
        6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };

endpackage

// ===== rtl/fpd_field_banks.sv =====
// ----------------------------------------------------------------------------
// fpd_field_banks
// Field grid split into four banks by column and row parity, so the four
// neighbors of a pixel are read in the same cycle. One write port shared.
// ----------------------------------------------------------------------------
module fpd_field_banks #(
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [3:0][AW-1:0]    i_rd_addr,
    output logic [3:0][7:0]       o_rd_data,
    input  logic [3:0]            i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [7:0]            i_wr_data
);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [0:DEPTH-1];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr_en[b]) begin
                mem[i_wr_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= mem[i_rd_addr[b]];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

// ===== rtl/fpd_palette_mem.sv =====
// ----------------------------------------------------------------------------
// fpd_palette_mem
// RGB palette, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpd_palette_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [23:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [23:0]   i_wr_data
);

    logic [23:0] mem [0:DEPTH-1];
    logic [23:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/fpd_dither.sv =====
// ----------------------------------------------------------------------------
// fpd_dither
// Ordered dither of one palette entry to 2 bits per channel, packed
// behind the alpha code.
// ----------------------------------------------------------------------------
module fpd_dither (
    input  logic [23:0] i_entry,
    input  logic [5:0]  i_dith,
    output logic [7:0]  o_pixel
);

    function automatic logic [1:0] quant(input logic [7:0] c, input logic [5:0] d);
        logic [13:0] prod;
        logic [8:0]  o;
        logic [8:0]  n;
        logic [2:0]  q;
        prod = {6'd0, c} * {8'd0, d};
        o    = ({1'b0, c} + 9'(prod >> fpd_pkg::DITH_SH)) >> 1;
        n    = (o + 9'((fpd_pkg::ROUND_MASK + 8'd1) >> 1)) & ~{1'b0, fpd_pkg::ROUND_MASK};
        q    = n[8:fpd_pkg::ROUND_SH];
        return (q > 3'(fpd_pkg::CHAN_MAX)) ? fpd_pkg::CHAN_MAX : q[1:0];
    endfunction

    logic [1:0] red_q;
    logic [1:0] green_q;
    logic [1:0] blue_q;

    always_comb begin
        red_q   = quant(i_entry[23:16], i_dith);
        green_q = quant(i_entry[15:8], i_dith);
        blue_q  = quant(i_entry[7:0], i_dith);
        o_pixel = 8'({4'd0, fpd_pkg::ALPHA_CODE} << 4) | {2'b00, red_q, green_q, blue_q};
    end

endmodule

// ===== rtl/field_palette_dither_pixel.sv =====
// ----------------------------------------------------------------------------
// field_palette_dither_pixel
// A render result passes stages 0 to 7 and is then held in the stage 8 output register.
// Throughput: one beat per cycle while the output is not stalled; nine elastic stages, bubbles collapse.
// Field and palette stores are each written in the stage that reads them,
// so every beat sees all earlier writes.
// Reset clears stage valid bits only; the stores stay undefined until written.
// ----------------------------------------------------------------------------
module field_palette_dither_pixel #(
    parameter int GRID_STEP    = fpd_pkg::GRID_STEP_DEF,
    parameter int FRAME_WIDTH  = fpd_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fpd_pkg::FRAME_HEIGHT_DEF,
    parameter int PALETTE_SIZE = fpd_pkg::PALETTE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_level,
    input  logic [7:0] i_palette_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixel
);

    localparam int NS     = fpd_pkg::NUM_STAGES;
    localparam int GRID_W = FRAME_WIDTH / GRID_STEP + 1;
    localparam int GRID_H = FRAME_HEIGHT / GRID_STEP + 1;
    localparam int BW     = (GRID_W + 1) / 2;
    localparam int BH     = (GRID_H + 1) / 2;
    localparam int BDEPTH = BW * BH;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int FRW    = $clog2(GRID_STEP);
    localparam int PAW    = $clog2(PALETTE_SIZE);
    localparam int PBW    = 8 + FRW;
    localparam int SB     = 8 + 2 * FRW + 1;
    localparam int MB     = ((1 << SB) + GRID_STEP - 1) / GRID_STEP;
    localparam int MBW    = SB + 1;
    localparam int S3     = 12;
    localparam int M3     = ((1 << S3) + 2) / 3;
    localparam int M3W    = 11;

    // constant tables
    logic [7:0]     div_tab [0:255];
    logic [FRW-1:0] mod_tab [0:255];
    logic [PAW-1:0] pal_tab [0:255];

    for (genvar i = 0; i < 256; i++) begin : g_tab
        assign div_tab[i] = 8'(i / GRID_STEP);
        assign mod_tab[i] = FRW'(i % GRID_STEP);
        assign pal_tab[i] = PAW'(i % PALETTE_SIZE);
    end

    // stage control
    logic [NS-1:0]        r_vld;
    logic [NS:0]          ld;
    fpd_pkg::t_side       r_side [0:NS-2];
    fpd_pkg::t_op         in_op;

    always_comb begin
        ld[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_ready = ld[0];

    always_comb begin
        unique case (i_kind)
            fpd_pkg::KIND_FIELD: begin
                in_op = (32'(i_pos_x) < GRID_W && 32'(i_pos_y) < GRID_H)
                        ? fpd_pkg::OP_FIELD_WR : fpd_pkg::OP_NONE;
            end
            fpd_pkg::KIND_PAL: begin
                in_op = (32'(i_palette_index) < PALETTE_SIZE)
                        ? fpd_pkg::OP_PAL_WR : fpd_pkg::OP_NONE;
            end
            fpd_pkg::KIND_RENDER: begin
                in_op = (32'(i_pos_x) < FRAME_WIDTH && 32'(i_pos_y) < FRAME_HEIGHT)
                        ? fpd_pkg::OP_RENDER : fpd_pkg::OP_NONE;
            end
            default: begin
                in_op = fpd_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_valid && (in_op != fpd_pkg::OP_NONE);
            end
            if (ld[1]) begin
                r_vld[1] <= r_vld[0] && (r_side[0].op == fpd_pkg::OP_PAL_WR ||
                                         r_side[0].op == fpd_pkg::OP_RENDER);
            end
            for (int k = 2; k < NS - 1; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (ld[NS-1]) begin
                r_vld[NS-1] <= r_vld[NS-2] && (r_side[NS-2].op == fpd_pkg::OP_RENDER);
            end
        end
    end

    // stage 0: input register
    logic [7:0] r_px;
    logic [7:0] r_py;
    logic [7:0] r_level;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_px           <= i_pos_x;
            r_py           <= i_pos_y;
            r_level        <= i_level;
            r_side[0].op   <= in_op;
            r_side[0].dith <= fpd_pkg::BAYER[{i_pos_y[2:0], i_pos_x[2:0]}];
            r_side[0].pidx <= i_palette_index;
            r_side[0].rgb  <= {i_red, i_green, i_blue};
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (ld[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage 0 comb: grid position, bank addresses, field write
    logic [7:0]           gx;
    logic [7:0]           gy;
    logic [FRW-1:0]       fx;
    logic [FRW-1:0]       fy;
    logic [3:0][BAW-1:0]  rd_addr;
    logic [3:0]           oob;
    logic [3:0]           fwr_en;
    logic [BAW-1:0]       fwr_addr;

    always_comb begin
        logic [8:0] cx;
        logic [8:0] cy;
        logic       bx;
        logic       by;
        gx = div_tab[r_px];
        gy = div_tab[r_py];
        fx = mod_tab[r_px];
        fy = mod_tab[r_py];
        for (int b = 0; b < 4; b++) begin
            bx = 1'(b);
            by = 1'(b >> 1);
            cx = {1'b0, gx} + 9'(gx[0] != bx);
            cy = {1'b0, gy} + 9'(gy[0] != by);
            oob[b] = (32'(cx) >= GRID_W) || (32'(cy) >= GRID_H);
            rd_addr[b] = oob[b] ? '0 : BAW'(32'(cy >> 1) * BW + 32'(cx >> 1));
            fwr_en[b] = r_vld[0] && ld[1] && (r_side[0].op == fpd_pkg::OP_FIELD_WR) &&
                        ({r_py[0], r_px[0]} == 2'(b));
        end
        fwr_addr = BAW'(32'(r_py >> 1) * BW + 32'(r_px >> 1));
    end

    logic [3:0][7:0] field_rd;

    fpd_field_banks #(
        .DEPTH (BDEPTH),
        .AW    (BAW)
    ) u_field_banks (
        .i_clk     (i_clk),
        .i_rd_en   (ld[1]),
        .i_rd_addr (rd_addr),
        .o_rd_data (field_rd),
        .i_wr_en   (fwr_en),
        .i_wr_addr (fwr_addr),
        .i_wr_data (r_level)
    );

    // stage 1: field data, vertical weights
    logic [FRW-1:0] r_fx [1:3];
    logic [FRW-1:0] r_fy1;
    logic [3:0]     r_oob1;
    logic           r_gx0;
    logic           r_gy0;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_fx[1] <= fx;
            r_fy1   <= fy;
            r_oob1  <= oob;
            r_gx0   <= gx[0];
            r_gy0   <= gy[0];
        end
        for (int k = 2; k <= 3; k++) begin
            if (ld[k]) begin
                r_fx[k] <= r_fx[k-1];
            end
        end
    end

    logic [3:0][7:0]     cells;
    logic [3:0][PBW-1:0] vprod;

    always_comb begin
        logic [1:0]     bi;
        logic [FRW-1:0] wlo;
        // cells order: (x,y), (x,y+1), (x+1,y), (x+1,y+1)
        for (int c = 0; c < 4; c++) begin
            bi = {r_gy0 ^ 1'(c), r_gx0 ^ 1'(c >> 1)};
            cells[c] = r_oob1[bi] ? 8'd0 : field_rd[bi];
        end
        wlo = FRW'(GRID_STEP - 1) - r_fy1;
        vprod[0] = PBW'(cells[0]) * PBW'(wlo);
        vprod[1] = PBW'(cells[1]) * PBW'(r_fy1);
        vprod[2] = PBW'(cells[2]) * PBW'(wlo);
        vprod[3] = PBW'(cells[3]) * PBW'(r_fy1);
    end

    // stage 2: products; divide by grid step
    logic [3:0][PBW-1:0] r_vprod2;
    logic [3:0][7:0]     vq;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_vprod2 <= vprod;
        end
    end

    always_comb begin
        logic [PBW+MBW-1:0] full;
        for (int k = 0; k < 4; k++) begin
            full  = (PBW+MBW)'(r_vprod2[k]) * (PBW+MBW)'(MB);
            vq[k] = full[SB +: 8];
        end
    end

    // stage 3: column sums, horizontal weights
    logic [3:0][7:0]     r_vq3;
    logic [1:0][PBW-1:0] hprod;

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_vq3 <= vq;
        end
    end

    always_comb begin
        logic [7:0]     s0;
        logic [7:0]     s1;
        logic [FRW-1:0] wlo;
        s0       = r_vq3[0] + r_vq3[1];
        s1       = r_vq3[2] + r_vq3[3];
        wlo      = FRW'(GRID_STEP - 1) - r_fx[3];
        hprod[0] = PBW'(s0) * PBW'(wlo);
        hprod[1] = PBW'(s1) * PBW'(r_fx[3]);
    end

    // stage 4: divide by grid step
    logic [1:0][PBW-1:0] r_hprod4;
    logic [1:0][7:0]     hq;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_hprod4 <= hprod;
        end
    end

    always_comb begin
        logic [PBW+MBW-1:0] full;
        for (int k = 0; k < 2; k++) begin
            full  = (PBW+MBW)'(r_hprod4[k]) * (PBW+MBW)'(MB);
            hq[k] = full[SB +: 8];
        end
    end

    // stage 5: blend, scale by 4/3, keep low byte
    logic [1:0][7:0] r_hq5;
    logic [7:0]      level_v;

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_hq5 <= hq;
        end
    end

    always_comb begin
        logic [7:0]      blend;
        logic [9:0]      x4;
        logic [M3W+9:0]  full;
        blend   = r_hq5[0] + r_hq5[1];
        x4      = {blend, 2'b00};
        full    = (M3W+10)'(x4) * (M3W+10)'(M3);
        level_v = full[S3 +: 8];
    end

    // stage 6: palette access
    logic [7:0]  r_v6;
    logic [23:0] pal_rd;
    logic        pwr_en;

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_v6 <= level_v;
        end
    end

    assign pwr_en = r_vld[6] && ld[7] && (r_side[6].op == fpd_pkg::OP_PAL_WR);

    fpd_palette_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (PAW)
    ) u_palette_mem (
        .i_clk     (i_clk),
        .i_rd_en   (ld[7]),
        .i_rd_addr (pal_tab[r_v6]),
        .o_rd_data (pal_rd),
        .i_wr_en   (pwr_en),
        .i_wr_addr (PAW'(r_side[6].pidx)),
        .i_wr_data (r_side[6].rgb)
    );

    // stage 7: dither and pack; stage 8: output register
    logic [7:0] pixel_d;
    logic [7:0] r_pixel;

    fpd_dither u_dither (
        .i_entry (pal_rd),
        .i_dith  (r_side[7].dith),
        .o_pixel (pixel_d)
    );

    always_ff @(posedge i_clk) begin
        if (ld[8]) begin
            r_pixel <= pixel_d;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_pixel = r_pixel;

endmodule

// ===== rtl/fpd_checker.sv =====
// ----------------------------------------------------------------------------
// fpd_checker
// Port-level checks for the palette dither pixel engine.
// ----------------------------------------------------------------------------
module fpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_kind,
    input logic [7:0] i_pos_x,
    input logic [7:0] i_pos_y,
    input logic [7:0] i_level,
    input logic [7:0] i_palette_index,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_kind) && $stable(i_pos_x) &&
        $stable(i_pos_y) && $stable(i_level) && $stable(i_palette_index) &&
        $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel))
        else $error("output beat dropped or changed while stalled");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel[7:6] == 2'b11)
        else $error("alpha bits not set");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with output empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind field_palette_dither_pixel fpd_checker u_fpd_checker (.*);
